// File: hdl/dlrb_pkg.sv
`timescale 1ns / 1ps

package dlrb_pkg;

	localparam int unsigned NUM_W = 24;  // 255*num + den/2 stays below 2**24
	localparam int unsigned DEN_W = 16;
	localparam int unsigned Q_W   = 8;

	localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
	localparam logic [7:0] CRC_INIT      = 8'h00;
	localparam logic [7:0] RATIO_FULL    = 8'd255;

	typedef struct packed {
		logic [31:0]        timestamp;
		logic signed [7:0]  midnight_temp;
		logic [7:0]         midnight_volt;
		logic signed [7:0]  noon_temp;
		logic [7:0]         noon_volt;
		logic [15:0]        wake_count;
		logic [15:0]        true_rx_count;
		logic [15:0]        tx_count;
		logic [7:0]         status_flags;
		logic [7:0]         noise_low;
		logic [7:0]         noise_high;
	} in_word_t;

	typedef struct packed {
		logic [63:0] record_low;
		logic [63:0] record_high;
		logic [7:0]  rx_ratio;
		logic [7:0]  tx_ratio;
		logic [7:0]  check_byte;
	} out_word_t;

	// record bytes that ride the pipeline unchanged
	typedef struct packed {
		logic [31:0] timestamp;
		logic [7:0]  midnight_temp;
		logic [7:0]  midnight_volt;
		logic [7:0]  noon_temp;
		logic [7:0]  noon_volt;
		logic [15:0] wake_count;
		logic [7:0]  status_flags;
		logic [7:0]  noise_low;
		logic [7:0]  noise_high;
	} fields_t;

	// ratio special cases, settled before the divide
	typedef struct packed {
		logic zero;
		logic sat;
	} ratio_flags_t;

	// one byte of the reflected CRC-8, LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] x;
		x = c ^ b;
		for (int k = 0; k < 8; k++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY_REFL) : (x >> 1);
		end
		return x;
	endfunction

	function automatic logic [7:0] ratio_pick(input ratio_flags_t f, input logic [Q_W-1:0] q);
		if (f.zero) begin
			return '0;
		end else if (f.sat) begin
			return RATIO_FULL;
		end
		return q;
	endfunction

endpackage

// File: hdl/dlrb_if.sv
`timescale 1ns / 1ps

interface dlrb_in_if;
	import dlrb_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface dlrb_out_if;
	import dlrb_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/dlrb_div_stage.sv
`timescale 1ns / 1ps

module dlrb_div_stage
	import dlrb_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] r_in,
	input  logic [DEN_W-1:0] den,
	input  logic [Q_W-1:0]   q_in,
	output logic [NUM_W-1:0] r_out,
	output logic [Q_W-1:0]   q_out
);

	localparam int unsigned LO = NUM_W - DEN_W - 1;

	logic [NUM_W-1:0] r_a, r_b;
	logic [DEN_W:0]   top_a, top_b;
	logic             bit_a, bit_b;

	// two restoring steps: compare the top bits against the divisor, subtract, shift
	always_comb begin
		top_a = r_in[NUM_W-1:LO];
		bit_a = top_a >= {1'b0, den};
		r_a   = r_in;
		if (bit_a) begin
			r_a[NUM_W-1:LO] = top_a - {1'b0, den};
		end
		r_a   = r_a << 1;

		top_b = r_a[NUM_W-1:LO];
		bit_b = top_b >= {1'b0, den};
		r_b   = r_a;
		if (bit_b) begin
			r_b[NUM_W-1:LO] = top_b - {1'b0, den};
		end
		r_b   = r_b << 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_out <= r_b;
			q_out <= {q_in[Q_W-3:0], bit_a, bit_b};
		end
	end

endmodule

// File: hdl/daily_log_record_builder.sv
`timescale 1ns / 1ps

// Daily log record builder. Each telemetry word becomes one 16-byte little-endian
// log record, delivered as two 64-bit halves together with the two ratio bytes and
// the check byte. The block is a seven-stage pipeline: it takes one word per clock
// whenever stage 1 has room, and each result moves through stages 2 to 7 and is
// offered from the stage 7 register. Every stage holds its own valid bit and advances
// whenever its successor has room, so bubbles close up and the input keeps accepting
// while a finished record waits on the output, until the stages fill. Stage 1 forms
// the scaled numerators 255*num + den/2 and settles the zero-divisor and saturation
// cases; stages 2 to 5 run the 8-bit restoring divides, two quotient bits per stage
// for each ratio; the CRC-8 (reflected polynomial 0x31, init 0) is folded in over
// stages 1 to 4, with the ratio bytes added in stage 6 and the trailing three bytes
// in stage 7, which is also the output register. No state survives between records.
module daily_log_record_builder
	import dlrb_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	dlrb_in_if.sink        telemetry,
	dlrb_out_if.source     record
);

	localparam int unsigned DIV_STAGES = Q_W / 2;

	// per-stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || record.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign telemetry.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= telemetry.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: numerators, special cases, CRC over bytes 0..2
	// ------------------------------------------------------------------
	in_word_t         w;
	logic [NUM_W-1:0] trx_w, tx_w, n_rx, n_tx;
	ratio_flags_t     frx, ftx;
	fields_t          f_in;
	logic [7:0]       crc_in;

	assign w = telemetry.payload;

	always_comb begin
		trx_w = {(NUM_W-DEN_W)'(0), w.true_rx_count};
		tx_w  = {(NUM_W-DEN_W)'(0), w.tx_count};
		// 255*x is x*256 - x; round by half the divisor
		n_rx  = (trx_w << 8) - trx_w + {(NUM_W-DEN_W+1)'(0), w.wake_count[DEN_W-1:1]};
		n_tx  = (tx_w << 8) - tx_w + {(NUM_W-DEN_W+1)'(0), w.true_rx_count[DEN_W-1:1]};
		frx.zero = w.wake_count == '0;
		ftx.zero = w.true_rx_count == '0;
		// quotient above 255 exactly when num >= 256*den
		frx.sat  = n_rx >= {w.wake_count, 8'd0};
		ftx.sat  = n_tx >= {w.true_rx_count, 8'd0};

		f_in.timestamp     = w.timestamp;
		f_in.midnight_temp = w.midnight_temp;
		f_in.midnight_volt = w.midnight_volt;
		f_in.noon_temp     = w.noon_temp;
		f_in.noon_volt     = w.noon_volt;
		f_in.wake_count    = w.wake_count;
		f_in.status_flags  = w.status_flags;
		f_in.noise_low     = w.noise_low;
		f_in.noise_high    = w.noise_high;

		crc_in = crc8_byte(CRC_INIT, w.timestamp[7:0]);
		crc_in = crc8_byte(crc_in, w.timestamp[15:8]);
		crc_in = crc8_byte(crc_in, w.timestamp[23:16]);
	end

	fields_t          f_s1, f_s2, f_s3, f_s4, f_s5, f_s6;
	ratio_flags_t     frx_s1, frx_s2, frx_s3, frx_s4, frx_s5;
	ratio_flags_t     ftx_s1, ftx_s2, ftx_s3, ftx_s4, ftx_s5;
	logic [DEN_W-1:0] dtx_s1, dtx_s2, dtx_s3, dtx_s4;
	logic [7:0]       crc_s1, crc_s2, crc_s3, crc_s4, crc_s5, crc_s6;
	logic [NUM_W-1:0] nrx_s1, ntx_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			f_s1   <= f_in;
			frx_s1 <= frx;
			ftx_s1 <= ftx;
			dtx_s1 <= w.true_rx_count;
			nrx_s1 <= n_rx;
			ntx_s1 <= n_tx;
			crc_s1 <= crc_in;
		end
	end

	// ------------------------------------------------------------------
	// Stages 2..5: restoring divides, two quotient bits per stage
	// ------------------------------------------------------------------
	logic [NUM_W-1:0] rrx [DIV_STAGES+1];
	logic [NUM_W-1:0] rtx [DIV_STAGES+1];
	logic [Q_W-1:0]   qrx [DIV_STAGES+1];
	logic [Q_W-1:0]   qtx [DIV_STAGES+1];
	logic [DEN_W-1:0] drx [DIV_STAGES];
	logic [DEN_W-1:0] dtx [DIV_STAGES];
	logic             den_en [DIV_STAGES];

	assign rrx[0] = nrx_s1;
	assign rtx[0] = ntx_s1;
	assign qrx[0] = '0;
	assign qtx[0] = '0;

	assign drx[0] = f_s1.wake_count;
	assign drx[1] = f_s2.wake_count;
	assign drx[2] = f_s3.wake_count;
	assign drx[3] = f_s4.wake_count;
	assign dtx[0] = dtx_s1;
	assign dtx[1] = dtx_s2;
	assign dtx[2] = dtx_s3;
	assign dtx[3] = dtx_s4;
	assign den_en[0] = en2;
	assign den_en[1] = en3;
	assign den_en[2] = en4;
	assign den_en[3] = en5;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		dlrb_div_stage u_rx (
			.clk   (clk),
			.en    (den_en[g]),
			.r_in  (rrx[g]),
			.den   (drx[g]),
			.q_in  (qrx[g]),
			.r_out (rrx[g+1]),
			.q_out (qrx[g+1])
		);
		dlrb_div_stage u_tx (
			.clk   (clk),
			.en    (den_en[g]),
			.r_in  (rtx[g]),
			.den   (dtx[g]),
			.q_in  (qtx[g]),
			.r_out (rtx[g+1]),
			.q_out (qtx[g+1])
		);
	end

	// carry the record bytes and the running CRC alongside the divides
	always_ff @(posedge clk) begin
		if (en2) begin
			f_s2   <= f_s1;
			frx_s2 <= frx_s1;
			ftx_s2 <= ftx_s1;
			dtx_s2 <= dtx_s1;
			crc_s2 <= crc8_byte(crc8_byte(crc8_byte(crc_s1, f_s1.timestamp[31:24]),
				f_s1.midnight_temp), f_s1.midnight_volt);
		end
		if (en3) begin
			f_s3   <= f_s2;
			frx_s3 <= frx_s2;
			ftx_s3 <= ftx_s2;
			dtx_s3 <= dtx_s2;
			crc_s3 <= crc8_byte(crc8_byte(crc8_byte(crc_s2, f_s2.noon_temp),
				f_s2.noon_volt), f_s2.wake_count[7:0]);
		end
		if (en4) begin
			f_s4   <= f_s3;
			frx_s4 <= frx_s3;
			ftx_s4 <= ftx_s3;
			dtx_s4 <= dtx_s3;
			crc_s4 <= crc8_byte(crc_s3, f_s3.wake_count[15:8]);
		end
		if (en5) begin
			f_s5   <= f_s4;
			frx_s5 <= frx_s4;
			ftx_s5 <= ftx_s4;
			crc_s5 <= crc_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: settle the ratio bytes and fold them into the CRC
	// ------------------------------------------------------------------
	logic [7:0] rx_r, tx_r;
	logic [7:0] rx_s6, tx_s6;

	assign rx_r = ratio_pick(frx_s5, qrx[DIV_STAGES]);
	assign tx_r = ratio_pick(ftx_s5, qtx[DIV_STAGES]);

	always_ff @(posedge clk) begin
		if (en6) begin
			f_s6   <= f_s5;
			rx_s6  <= rx_r;
			tx_s6  <= tx_r;
			crc_s6 <= crc8_byte(crc8_byte(crc_s5, rx_r), tx_r);
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: last three bytes of the CRC, pack the record, output register
	// ------------------------------------------------------------------
	logic [7:0] crc_fin;
	out_word_t  o_s7;

	assign crc_fin = crc8_byte(crc8_byte(crc8_byte(crc_s6, f_s6.status_flags),
		f_s6.noise_low), f_s6.noise_high);

	always_ff @(posedge clk) begin
		if (en7) begin
			o_s7.record_low  <= {f_s6.noon_volt, f_s6.noon_temp, f_s6.midnight_volt,
				f_s6.midnight_temp, f_s6.timestamp};
			o_s7.record_high <= {crc_fin, f_s6.noise_high, f_s6.noise_low,
				f_s6.status_flags, tx_s6, rx_s6, f_s6.wake_count};
			o_s7.rx_ratio    <= rx_s6;
			o_s7.tx_ratio    <= tx_s6;
			o_s7.check_byte  <= crc_fin;
		end
	end

	assign record.valid   = v_s7;
	assign record.payload = o_s7;

endmodule

// File: verif/tb_daily_log_record_builder.sv
`timescale 1ns / 1ps

// Self-checking bench for the daily log record builder.
module tb_daily_log_record_builder;
	import dlrb_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1930;
	localparam int unsigned IDLE_PCT     = 36;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 20;     // pipeline is seven deep, leave margin
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;

	dlrb_in_if  telemetry_bus ();
	dlrb_out_if record_bus ();

	daily_log_record_builder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.telemetry (telemetry_bus),
		.record    (record_bus)
	);

	// Shared knobs: idle percentage for both sides, and a one-shot request
	// for a long output hold-off.
	int unsigned idle_pct = IDLE_PCT;
	bit          hold_req = 1'b0;

	// Rounded ratio 255*num/den: add half the divisor, divide, clamp at 255.
	// A zero divisor gives zero.
	function automatic logic [7:0] scaled_ratio(input logic [15:0] num, input logic [15:0] den);
		logic [31:0] quot;
		if (den == 16'd0) begin
			return 8'd0;
		end
		quot = (32'd255 * num + {17'd0, den[15:1]}) / {16'd0, den};
		return (quot > 32'd255) ? 8'hFF : quot[7:0];
	endfunction

	// Build the expected record. Bytes 0..14 are laid out little-endian in a
	// 120-bit vector, so bit i of the vector is bit i%8 of byte i/8, which is
	// exactly the order a reflected CRC consumes them in.
	function automatic out_word_t build_record(input in_word_t w);
		out_word_t   rec;
		logic [55:0] upper_body;
		logic [119:0] crc_span;
		logic [7:0]  crc;
		logic        fb;
		rec.rx_ratio   = scaled_ratio(w.true_rx_count, w.wake_count);
		rec.tx_ratio   = scaled_ratio(w.tx_count, w.true_rx_count);
		rec.record_low = {w.noon_volt, w.noon_temp, w.midnight_volt, w.midnight_temp,
			w.timestamp};
		upper_body = {w.noise_high, w.noise_low, w.status_flags, rec.tx_ratio,
			rec.rx_ratio, w.wake_count};
		crc_span = {upper_body, rec.record_low};
		// bitwise form of the LSB-first CRC-8: feed one bit at a time
		crc = CRC_INIT;
		for (int i = 0; i < 120; i++) begin
			fb  = crc[0] ^ crc_span[i];
			crc = crc >> 1;
			if (fb) begin
				crc = crc ^ CRC_POLY_REFL;
			end
		end
		rec.check_byte  = crc;
		rec.record_high = {crc, upper_body};
		return rec;
	endfunction

	// Keep expected records in acceptance order and compare each output word
	// against the oldest one.
	class record_scoreboard;
		out_word_t   expected_q[$];
		int unsigned fail_count;

		function new();
			fail_count = 0;
		endfunction

		function void note_word(input in_word_t w);
			expected_q.push_back(build_record(w));
		endfunction

		function void check_record(input out_word_t got);
			out_word_t want;
			if (expected_q.size() == 0) begin
				$error("record word with nothing expected: low %h high %h",
					got.record_low, got.record_high);
				fail_count++;
				return;
			end
			want = expected_q.pop_front();
			if (got.record_low !== want.record_low) begin
				$error("record_low: expected %h, got %h", want.record_low, got.record_low);
				fail_count++;
			end
			if (got.record_high !== want.record_high) begin
				$error("record_high: expected %h, got %h", want.record_high, got.record_high);
				fail_count++;
			end
			if (got.rx_ratio !== want.rx_ratio) begin
				$error("rx_ratio: expected %0d, got %0d", want.rx_ratio, got.rx_ratio);
				fail_count++;
			end
			if (got.tx_ratio !== want.tx_ratio) begin
				$error("tx_ratio: expected %0d, got %0d", want.tx_ratio, got.tx_ratio);
				fail_count++;
			end
			if (got.check_byte !== want.check_byte) begin
				$error("check_byte: expected %h, got %h", want.check_byte, got.check_byte);
				fail_count++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction
	endclass

	record_scoreboard records = new();

	// Counts for the ratios: lean on zero, all-ones and tiny values, where
	// the divide and the clamp have their corners.
	function automatic logic [15:0] pick_count();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	// Draw one telemetry word. Most words look like a real day: receptions
	// do not exceed wakeups and transmissions stay near receptions. The rest
	// are unconstrained, which drives the clamp and the zero-divisor path.
	function automatic in_word_t random_telemetry();
		in_word_t w;
		w = in_word_t'({$urandom, $urandom, $urandom, $urandom, 8'($urandom)});
		if ($urandom_range(99) < 70) begin
			w.wake_count    = pick_count();
			w.true_rx_count = (w.wake_count == 16'd0) ? 16'd0 :
				16'($urandom_range(0, w.wake_count));
			w.tx_count      = 16'($urandom_range(0, 2 * w.true_rx_count + 1));
		end else begin
			w.wake_count    = pick_count();
			w.true_rx_count = pick_count();
			w.tx_count      = pick_count();
		end
		return w;
	endfunction

	// Offer one word: idle at random first, then hold valid and the payload
	// until the block takes it. Never drop valid between back-to-back words.
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			telemetry_bus.valid <= 1'b0;
			@(posedge clk);
		end
		telemetry_bus.valid   <= 1'b1;
		telemetry_bus.payload <= w;
		do begin
			@(posedge clk);
		end while (!telemetry_bus.ready);
		records.note_word(w);
	endtask

	// Wait until every expected record has come back.
	task automatic wait_drained();
		while (records.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	// Watchdog: stop a hung run.
	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Output side: check each accepted record word, then pick ready for the
	// next edge. A hold-off request drops ready for a long stretch counted
	// here, so the pipeline backs up into the input.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		record_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && record_bus.valid && record_bus.ready) begin
				records.check_record(record_bus.payload);
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				record_bus.ready <= 1'b0;
			end else begin
				record_bus.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Input side and run control.
	initial begin
		in_word_t w;
		telemetry_bus.valid   <= 1'b0;
		telemetry_bus.payload <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: field extremes, zero divisors, clamping and the
		// rounding boundaries of the ratios.
		for (int n = 0; n < 22; n++) begin
			w = random_telemetry();
			case (n)
				0: w = '0;
				1: w = '1;
				2: begin
					w.midnight_temp = -8'sd128;
					w.noon_temp     = 8'sd127;
				end
				3: begin
					w.midnight_temp = 8'sd127;
					w.noon_temp     = -8'sd128;
					w.timestamp     = 32'hFFFF_FFFF;
				end
				4: begin  // no wakeups: rx ratio forced to zero
					w.wake_count    = 16'd0;
					w.true_rx_count = 16'hFFFF;
				end
				5: begin  // no receptions: tx ratio forced to zero
					w.true_rx_count = 16'd0;
					w.tx_count      = 16'hFFFF;
				end
				6: begin  // both divisors zero
					w.wake_count    = 16'd0;
					w.true_rx_count = 16'd0;
				end
				7: begin  // more receptions than wakeups: clamp
					w.wake_count    = 16'd1;
					w.true_rx_count = 16'hFFFF;
				end
				8: begin  // tx far above rx: clamp
					w.true_rx_count = 16'd1;
					w.tx_count      = 16'd2;
				end
				9: begin  // half rounds up
					w.wake_count    = 16'd2;
					w.true_rx_count = 16'd1;
				end
				10: begin  // exactly one after rounding
					w.wake_count    = 16'd510;
					w.true_rx_count = 16'd1;
				end
				11: begin  // just below one half step: rounds to zero
					w.wake_count    = 16'd511;
					w.true_rx_count = 16'd1;
				end
				12: begin  // smallest nonzero over the largest divisor
					w.wake_count    = 16'hFFFF;
					w.true_rx_count = 16'd1;
					w.tx_count      = 16'd1;
				end
				13: begin  // full scale on both ratios
					w.wake_count    = 16'hFFFF;
					w.true_rx_count = 16'hFFFF;
					w.tx_count      = 16'hFFFF;
				end
				14: begin
					w.status_flags = 8'hFF;
					w.noise_low    = 8'h00;
					w.noise_high   = 8'hFF;
				end
				15: begin
					w.status_flags = 8'h00;
					w.noise_low    = 8'hFF;
					w.noise_high   = 8'h00;
				end
				16: begin
					w.timestamp     = 32'h8000_0001;
					w.midnight_volt = 8'hFF;
					w.noon_volt     = 8'h00;
				end
				17: begin  // ratio just under the clamp
					w.wake_count    = 16'd255;
					w.true_rx_count = 16'd254;
				end
				default: ;
			endcase
			send_word(w);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// run a stretch with both sides streaming and no gaps
			if (n == 400) begin
				idle_pct = 0;
			end
			if (n == 700) begin
				idle_pct = IDLE_PCT;
			end
			// stall the output for a long while and keep offering words
			if (n == 1200) begin
				hold_req = 1'b1;
			end
			// pause the input until the pipeline is empty
			if (n == 1500) begin
				telemetry_bus.valid <= 1'b0;
				wait_drained();
			end
			send_word(random_telemetry());
		end
		telemetry_bus.valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (records.fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
